>>> rtl/i2cbm_pkg.sv
package i2cbm_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_RETRY  = 2'd2;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_ADDR  = 3'd1;
    localparam logic [2:0] OP_SEND  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam logic [15:0] UNIT_TICKS_RST   = 16'd1;
    localparam logic [15:0] ACK_POLL_RST     = 16'd2000;
    localparam logic [7:0]  ADDR_RETRY_RST   = 8'd10;
    localparam logic [7:0]  ADDR_DIR_MASK    = 8'hFE;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       read_dir;
        logic       master_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       cmd_done;
        logic       ack_status;
        logic [7:0] read_byte;
    } t_out_item;

    // classified tick as it travels from front to back
    typedef struct packed {
        logic       cmd;
        logic [2:0] op;
        logic [7:0] data;
        logic       mack;
        logic       sda;
    } t_tick;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_SB_LOW  = 5'd3,
        PH_SB_DATA = 5'd4,
        PH_SB_H1   = 5'd5,
        PH_SB_H2   = 5'd6,
        PH_SA_1    = 5'd7,
        PH_SA_2    = 5'd8,
        PH_SA_3    = 5'd9,
        PH_SA_4    = 5'd10,
        PH_POLL    = 5'd11,
        PH_RB_1    = 5'd12,
        PH_RB_2    = 5'd13,
        PH_RB_3    = 5'd14,
        PH_RB_H1   = 5'd15,
        PH_RB_H2   = 5'd16,
        PH_RA_1    = 5'd17,
        PH_RA_2    = 5'd18,
        PH_RA_3    = 5'd19,
        PH_RA_4    = 5'd20,
        PH_SP_1    = 5'd21,
        PH_SP_2    = 5'd22
    } t_phase;

endpackage

>>> rtl/i2cbm_front.sv
module i2cbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  i2cbm_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    output i2cbm_pkg::t_tick  o_q_tick,
    input  logic              i_q_pop
);
    import i2cbm_pkg::*;

    t_tick       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_count;
    logic        push;
    logic        pop;
    t_tick       tick;

    // classify: legal command and the byte that goes out on the bus
    always_comb begin
        tick.cmd  = i_in_item.cmd_valid && (i_in_item.opcode <= OP_STOP);
        tick.op   = i_in_item.opcode;
        tick.mack = i_in_item.master_ack;
        tick.sda  = i_in_item.sda_in;
        if (i_in_item.opcode == OP_ADDR) begin
            tick.data = (i_in_item.data_byte & ADDR_DIR_MASK) | {7'd0, i_in_item.read_dir};
        end else begin
            tick.data = i_in_item.data_byte;
        end
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_tick   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= tick;
        end
    end

endmodule

>>> rtl/i2cbm_back.sv
module i2cbm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_q_valid,
    input  i2cbm_pkg::t_tick                   i_q_tick,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output i2cbm_pkg::t_out_item               o_out_item
);
    import i2cbm_pkg::*;

    logic [15:0] r_unit_ticks;
    logic [15:0] r_ack_poll;
    logic [7:0]  r_addr_retry;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_unit_count, n_unit_count;
    logic [15:0] r_poll_count, n_poll_count;
    logic [7:0]  r_retry, n_retry;
    logic        r_ack, n_ack;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drive, n_drive;
    logic        r_cur_addr, n_cur_addr;
    logic [7:0]  r_addr_hold, n_addr_hold;
    logic        r_ack_bit, n_ack_bit;
    logic [7:0]  r_rd_hold, n_rd_hold;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        fin;
    logic        pop;
    logic [15:0] unit_lim;
    logic [15:0] poll_lim;
    logic [7:0]  retry_lim;
    logic [15:0] uc_inc;
    logic        unit_end;
    logic [3:0]  bit_inc;
    logic        bits_more;
    logic [7:0]  retry_inc;
    logic        retry_out;
    logic        poll_done;
    logic        ack_call;
    logic        ack_nack;
    logic        retry_again;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RST;
            r_ack_poll   <= ACK_POLL_RST;
            r_addr_retry <= ADDR_RETRY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UNIT_TICKS: r_unit_ticks <= i_cfg_data;
                CFG_ACK_POLL:   r_ack_poll   <= i_cfg_data;
                CFG_ADDR_RETRY: r_addr_retry <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = pop;

    // zero limits behave as one
    assign unit_lim  = (r_unit_ticks == 16'd0) ? 16'd1 : r_unit_ticks;
    assign poll_lim  = (r_ack_poll == 16'd0) ? 16'd1 : r_ack_poll;
    assign retry_lim = (r_addr_retry == 8'd0) ? 8'd1 : r_addr_retry;

    assign uc_inc    = r_unit_count + 16'd1;
    assign unit_end  = (r_phase != PH_IDLE) && (uc_inc >= unit_lim);
    assign bit_inc   = r_bit_count + 4'd1;
    assign bits_more = (bit_inc < BITS_PER_BYTE);
    assign retry_inc = r_retry + 8'd1;
    assign retry_out = (retry_inc >= retry_lim);
    assign poll_done = (r_poll_count >= poll_lim);

    // acknowledge sample outcome in the two sampling phases
    always_comb begin
        ack_call = 1'b0;
        ack_nack = 1'b0;
        case (r_phase)
            PH_SA_4: begin
                ack_call = !i_q_tick.sda;
            end
            PH_POLL: begin
                ack_call = poll_done || !i_q_tick.sda;
                ack_nack = poll_done;
            end
            default: ;
        endcase
    end

    assign retry_again = r_cur_addr && ack_nack && !retry_out;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (pop) begin
            if (r_phase == PH_IDLE) begin
                if (i_q_tick.cmd) begin
                    case (i_q_tick.op)
                        OP_START: n_phase = PH_ST_A;
                        OP_ADDR:  n_phase = PH_ST_A;
                        OP_SEND:  n_phase = PH_SB_LOW;
                        OP_READ:  n_phase = PH_RB_1;
                        default:  n_phase = PH_SP_1;
                    endcase
                end
            end else if (unit_end) begin
                case (r_phase)
                    PH_ST_A:    n_phase = PH_ST_B;
                    PH_ST_B:    n_phase = r_cur_addr ? PH_SB_LOW : PH_IDLE;
                    PH_SB_LOW:  n_phase = PH_SB_DATA;
                    PH_SB_DATA: n_phase = PH_SB_H1;
                    PH_SB_H1:   n_phase = PH_SB_H2;
                    PH_SB_H2:   n_phase = bits_more ? PH_SB_LOW : PH_SA_1;
                    PH_SA_1:    n_phase = PH_SA_2;
                    PH_SA_2:    n_phase = PH_SA_3;
                    PH_SA_3:    n_phase = PH_SA_4;
                    PH_SA_4, PH_POLL: begin
                        if (ack_call) begin
                            n_phase = retry_again ? PH_ST_A : PH_IDLE;
                        end else begin
                            n_phase = PH_POLL;
                        end
                    end
                    PH_RB_1:    n_phase = PH_RB_2;
                    PH_RB_2:    n_phase = PH_RB_3;
                    PH_RB_3:    n_phase = PH_RB_H1;
                    PH_RB_H1:   n_phase = PH_RB_H2;
                    PH_RB_H2:   n_phase = bits_more ? PH_RB_1 : PH_RA_1;
                    PH_RA_1:    n_phase = PH_RA_2;
                    PH_RA_2:    n_phase = PH_RA_3;
                    PH_RA_3:    n_phase = PH_RA_4;
                    PH_RA_4:    n_phase = PH_IDLE;
                    PH_SP_1:    n_phase = PH_SP_2;
                    PH_SP_2:    n_phase = PH_IDLE;
                    default:    n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // pins, counters and data
    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_unit_count = r_unit_count;
        n_poll_count = r_poll_count;
        n_retry      = r_retry;
        n_ack        = r_ack;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drive      = r_drive;
        n_cur_addr   = r_cur_addr;
        n_addr_hold  = r_addr_hold;
        n_ack_bit    = r_ack_bit;
        n_rd_hold    = r_rd_hold;
        fin          = 1'b0;
        if (pop) begin
            if (r_phase == PH_IDLE) begin
                if (i_q_tick.cmd) begin
                    n_unit_count = 16'd0;
                    n_cur_addr   = (i_q_tick.op == OP_ADDR);
                    case (i_q_tick.op)
                        OP_START: begin
                            n_drive = 1'b1;
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                        end
                        OP_ADDR: begin
                            n_addr_hold = i_q_tick.data;
                            n_retry     = 8'd0;
                            n_drive     = 1'b1;
                            n_sda       = 1'b1;
                            n_scl       = 1'b1;
                        end
                        OP_SEND: begin
                            n_shift      = i_q_tick.data;
                            n_drive      = 1'b1;
                            n_bit_count  = 4'd0;
                            n_poll_count = 16'd0;
                            n_scl        = 1'b0;
                        end
                        OP_READ: begin
                            n_ack_bit   = i_q_tick.mack;
                            n_drive     = 1'b0;
                            n_bit_count = 4'd0;
                            n_shift     = 8'd0;
                            n_scl       = 1'b0;
                        end
                        default: begin
                            n_drive = 1'b1;
                            n_sda   = 1'b0;
                            n_scl   = 1'b1;
                        end
                    endcase
                end
            end else if (!unit_end) begin
                n_unit_count = uc_inc;
            end else begin
                n_unit_count = 16'd0;
                case (r_phase)
                    PH_ST_A: n_sda = 1'b0;
                    PH_ST_B: begin
                        n_scl = 1'b0;
                        if (r_cur_addr) begin
                            n_shift      = r_addr_hold;
                            n_drive      = 1'b1;
                            n_bit_count  = 4'd0;
                            n_poll_count = 16'd0;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    PH_SB_LOW:  n_sda = r_shift[7];
                    PH_SB_DATA: n_scl = 1'b1;
                    PH_SB_H2: begin
                        n_shift     = {r_shift[6:0], 1'b0};
                        n_bit_count = bit_inc;
                        n_scl       = 1'b0;
                        if (!bits_more) begin
                            n_drive = 1'b0;
                        end
                    end
                    PH_SA_2: n_scl = 1'b1;
                    PH_SA_4, PH_POLL: begin
                        if (r_phase == PH_SA_4) begin
                            n_poll_count = 16'd0;
                        end
                        if (ack_call) begin
                            n_scl = 1'b0;
                            if (r_cur_addr) begin
                                if (!ack_nack) begin
                                    n_ack = 1'b0;
                                    fin   = 1'b1;
                                end else begin
                                    n_retry = retry_inc;
                                    if (retry_out) begin
                                        n_ack = 1'b1;
                                        fin   = 1'b1;
                                    end else begin
                                        n_drive = 1'b1;
                                        n_sda   = 1'b1;
                                        n_scl   = 1'b1;
                                    end
                                end
                            end else begin
                                n_ack = ack_nack;
                                fin   = 1'b1;
                            end
                        end else if (r_phase == PH_SA_4) begin
                            n_poll_count = 16'd1;
                        end else begin
                            n_poll_count = r_poll_count + 16'd1;
                        end
                    end
                    PH_RB_3: n_scl = 1'b1;
                    PH_RB_H2: begin
                        n_shift     = {r_shift[6:0], i_q_tick.sda};
                        n_bit_count = bit_inc;
                        n_scl       = 1'b0;
                        if (!bits_more) begin
                            n_drive = 1'b1;
                        end
                    end
                    PH_RA_1: n_sda = r_ack_bit;
                    PH_RA_2: n_scl = 1'b1;
                    PH_RA_4: begin
                        n_scl     = 1'b0;
                        n_rd_hold = r_shift;
                        fin       = 1'b1;
                    end
                    PH_SP_1: n_sda = 1'b1;
                    PH_SP_2: fin = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_shift      <= 8'd0;
            r_unit_count <= 16'd0;
            r_poll_count <= 16'd0;
            r_retry      <= 8'd0;
            r_ack        <= 1'b1;
            r_scl        <= 1'b0;
            r_sda        <= 1'b0;
            r_drive      <= 1'b1;
            r_cur_addr   <= 1'b0;
            r_addr_hold  <= 8'd0;
            r_ack_bit    <= 1'b0;
            r_rd_hold    <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_unit_count <= n_unit_count;
            r_poll_count <= n_poll_count;
            r_retry      <= n_retry;
            r_ack        <= n_ack;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drive      <= n_drive;
            r_cur_addr   <= n_cur_addr;
            r_addr_hold  <= n_addr_hold;
            r_ack_bit    <= n_ack_bit;
            r_rd_hold    <= n_rd_hold;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.scl_level  <= n_scl;
            r_out.sda_level  <= n_drive && n_sda;
            r_out.sda_drive  <= n_drive;
            r_out.busy_res   <= (n_phase != PH_IDLE);
            r_out.cmd_done   <= fin;
            r_out.ack_status <= n_ack;
            r_out.read_byte  <= n_rd_hold;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> rtl/i2c_bit_master_top.sv
// i2c bit master: bit-level bus engine advanced by one input transaction per tick
//
// input channel: i_in_valid / o_in_stall with i_in_item; every transaction is one
// bus tick carrying the sampled sda level and, while idle, an optional command
// output channel: o_out_valid / i_out_stall with o_out_item; exactly one result
// transaction per input transaction, in order, showing the pins after that tick
// config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects unit_ticks,
// ack_poll_limit or addr_retry_limit; write only while the engine is idle
//
// latency: two cycles from input accept to the earliest result accept (one cycle
// in the two-entry tick queue, one in the output register)
// throughput: one transaction per cycle, set by the single-cycle engine step
// when the receiver stalls, the result is held and the queue absorbs two more
// ticks before o_in_stall rises
// reset: engine idle, scl low, sda driven low, ack status set, limits at defaults
module i2c_bit_master_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  i2cbm_pkg::t_in_item                i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output i2cbm_pkg::t_out_item               o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import i2cbm_pkg::*;

    logic  q_valid;
    logic  q_pop;
    t_tick q_tick;

    i2cbm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_tick   (q_tick),
        .i_q_pop    (q_pop)
    );

    i2cbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_tick    (q_tick),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.cmd_done) |-> !o_out_item.busy_res)
        else $error("command done reported while still busy");

    a_released_sda_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.sda_drive) |-> !o_out_item.sda_level)
        else $error("sda level set while released");

    a_full_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("queue full with empty output register");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("engine took a tick from an empty queue");

endmodule

>>> tb/i2cbm_checker.sv
`timescale 1ns / 100ps
module i2cbm_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  i2cbm_pkg::t_in_item                i_in_item,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  i2cbm_pkg::t_out_item               i_out_item,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output logic                               o_engine_idle
);
    import i2cbm_pkg::*;

    logic [15:0] unit_ticks;
    logic [15:0] poll_limit;
    logic [7:0]  retry_limit;

    t_phase      ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] unit_cnt;
    logic [15:0] poll_cnt;
    logic [7:0]  retry_cnt;
    logic        ack_flag;
    logic        scl;
    logic        sda;
    logic        drv;
    logic [2:0]  cur_op;
    logic [7:0]  addr_hold;
    logic        ack_bit;
    logic [7:0]  rd_hold;
    logic        done;

    t_out_item   expected_pins[$];
    t_out_item   want;
    int          fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_engine_idle = 1'b1;
    end

    function void begin_start();
        drv = 1'b1;
        sda = 1'b1;
        scl = 1'b1;
        ph = PH_ST_A;
    endfunction

    function void begin_send();
        drv = 1'b1;
        bit_cnt = '0;
        poll_cnt = '0;
        scl = 1'b0;
        ph = PH_SB_LOW;
    endfunction

    function void end_cmd();
        ph = PH_IDLE;
        done = 1'b1;
    endfunction

    function void end_send(input logic nack);
        logic [7:0] lim;
        lim = (retry_limit == 0) ? 8'd1 : retry_limit;
        scl = 1'b0;
        if (cur_op == OP_ADDR) begin
            if (!nack) begin
                ack_flag = 1'b0;
                end_cmd();
            end else begin
                retry_cnt = retry_cnt + 8'd1;
                if (retry_cnt >= lim) begin
                    ack_flag = 1'b1;
                    end_cmd();
                end else begin
                    begin_start();
                end
            end
        end else begin
            ack_flag = nack;
            end_cmd();
        end
    endfunction

    function void check_ack(input logic line);
        if (!line) begin
            end_send(1'b0);
        end else begin
            poll_cnt = poll_cnt + 16'd1;
            ph = PH_POLL;
        end
    endfunction

    function t_out_item advance_bus(input t_in_item it);
        logic [15:0] ulim;
        logic [15:0] plim;
        t_out_item   r;
        done = 1'b0;
        if (ph == PH_IDLE) begin
            if (it.cmd_valid && it.opcode <= OP_STOP) begin
                unit_cnt = '0;
                cur_op = it.opcode;
                case (it.opcode)
                    OP_START: begin_start();
                    OP_ADDR: begin
                        addr_hold = (it.data_byte & ADDR_DIR_MASK) | {7'd0, it.read_dir};
                        retry_cnt = '0;
                        begin_start();
                    end
                    OP_SEND: begin
                        shreg = it.data_byte;
                        begin_send();
                    end
                    OP_READ: begin
                        ack_bit = it.master_ack;
                        drv = 1'b0;
                        bit_cnt = '0;
                        shreg = '0;
                        scl = 1'b0;
                        ph = PH_RB_1;
                    end
                    default: begin
                        drv = 1'b1;
                        sda = 1'b0;
                        scl = 1'b1;
                        ph = PH_SP_1;
                    end
                endcase
            end
        end else begin
            ulim = (unit_ticks == 0) ? 16'd1 : unit_ticks;
            plim = (poll_limit == 0) ? 16'd1 : poll_limit;
            unit_cnt = unit_cnt + 16'd1;
            if (unit_cnt >= ulim) begin
                unit_cnt = '0;
                case (ph)
                    PH_ST_A: begin
                        sda = 1'b0;
                        ph = PH_ST_B;
                    end
                    PH_ST_B: begin
                        scl = 1'b0;
                        if (cur_op == OP_ADDR) begin
                            shreg = addr_hold;
                            begin_send();
                        end else begin
                            end_cmd();
                        end
                    end
                    PH_SB_LOW: begin
                        sda = shreg[7];
                        ph = PH_SB_DATA;
                    end
                    PH_SB_DATA: begin
                        scl = 1'b1;
                        ph = PH_SB_H1;
                    end
                    PH_SB_H1: ph = PH_SB_H2;
                    PH_SB_H2: begin
                        shreg = {shreg[6:0], 1'b0};
                        bit_cnt = bit_cnt + 4'd1;
                        scl = 1'b0;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            ph = PH_SB_LOW;
                        end else begin
                            drv = 1'b0;
                            ph = PH_SA_1;
                        end
                    end
                    PH_SA_1: ph = PH_SA_2;
                    PH_SA_2: begin
                        scl = 1'b1;
                        ph = PH_SA_3;
                    end
                    PH_SA_3: ph = PH_SA_4;
                    PH_SA_4: begin
                        poll_cnt = '0;
                        check_ack(it.sda_in);
                    end
                    PH_POLL: begin
                        if (poll_cnt >= plim) begin
                            end_send(1'b1);
                        end else begin
                            check_ack(it.sda_in);
                        end
                    end
                    PH_RB_1: ph = PH_RB_2;
                    PH_RB_2: ph = PH_RB_3;
                    PH_RB_3: begin
                        scl = 1'b1;
                        ph = PH_RB_H1;
                    end
                    PH_RB_H1: ph = PH_RB_H2;
                    PH_RB_H2: begin
                        shreg = {shreg[6:0], it.sda_in};
                        bit_cnt = bit_cnt + 4'd1;
                        scl = 1'b0;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            ph = PH_RB_1;
                        end else begin
                            drv = 1'b1;
                            ph = PH_RA_1;
                        end
                    end
                    PH_RA_1: begin
                        sda = ack_bit;
                        ph = PH_RA_2;
                    end
                    PH_RA_2: begin
                        scl = 1'b1;
                        ph = PH_RA_3;
                    end
                    PH_RA_3: ph = PH_RA_4;
                    PH_RA_4: begin
                        scl = 1'b0;
                        rd_hold = shreg;
                        end_cmd();
                    end
                    PH_SP_1: begin
                        sda = 1'b1;
                        ph = PH_SP_2;
                    end
                    PH_SP_2: end_cmd();
                    default: ph = PH_IDLE;
                endcase
            end
        end
        r.scl_level = scl;
        r.sda_level = drv & sda;
        r.sda_drive = drv;
        r.busy_res = (ph != PH_IDLE);
        r.cmd_done = done;
        r.ack_status = ack_flag;
        r.read_byte = rd_hold;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unit_ticks = UNIT_TICKS_RST;
            poll_limit = ACK_POLL_RST;
            retry_limit = ADDR_RETRY_RST;
            ph = PH_IDLE;
            bit_cnt = '0;
            shreg = '0;
            unit_cnt = '0;
            poll_cnt = '0;
            retry_cnt = '0;
            ack_flag = 1'b1;
            scl = 1'b0;
            sda = 1'b0;
            drv = 1'b1;
            cur_op = OP_START;
            addr_hold = '0;
            ack_bit = 1'b0;
            rd_hold = '0;
            done = 1'b0;
            expected_pins.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_UNIT_TICKS: unit_ticks = i_cfg_data;
                    CFG_ACK_POLL: poll_limit = i_cfg_data;
                    CFG_ADDR_RETRY: retry_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pins.size() == 0) begin
                    $display("%0t: result with no transaction pending, expected none, actual %p",
                             $time, i_out_item);
                    fails++;
                end else begin
                    want = expected_pins.pop_front();
                    report_field("scl_level", 8'(want.scl_level),
                                 8'(i_out_item.scl_level));
                    report_field("sda_level", 8'(want.sda_level),
                                 8'(i_out_item.sda_level));
                    report_field("sda_drive", 8'(want.sda_drive),
                                 8'(i_out_item.sda_drive));
                    report_field("busy_res", 8'(want.busy_res),
                                 8'(i_out_item.busy_res));
                    report_field("cmd_done", 8'(want.cmd_done),
                                 8'(i_out_item.cmd_done));
                    report_field("ack_status", 8'(want.ack_status),
                                 8'(i_out_item.ack_status));
                    report_field("read_byte", want.read_byte, i_out_item.read_byte);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pins.push_back(advance_bus(i_in_item));
            end
        end
        o_pending <= expected_pins.size();
        o_fail_count <= fails;
        o_engine_idle <= (ph == PH_IDLE);
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import i2cbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_TICKS = 240;
    localparam int RANDOM_PHASES = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    t_in_item               in_item;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int          fail_count;
    int          pending;
    logic        engine_idle;
    int          idle_cycles = 0;
    int          burst_left;
    int          ticks_sent;
    int          sda_bias;
    int          stall_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    bit          noise_on;
    bit          last_quiet;

    i2c_bit_master_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    i2cbm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_engine_idle(engine_idle)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE: out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_left % 4 < 2);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_bias();
        case ($urandom_range(0, 4))
            0, 1: return 0;
            2: return 40;
            3: return 85;
            default: return 100;
        endcase
    endfunction

    function automatic t_in_item filler();
        t_in_item it;
        it.cmd_valid = noise_on && !engine_idle && ($urandom_range(0, 7) == 0);
        it.opcode = 3'($urandom_range(0, 7));
        it.data_byte = 8'($urandom_range(0, 255));
        it.read_dir = 1'($urandom_range(0, 1));
        it.master_ack = 1'($urandom_range(0, 1));
        it.sda_in = ($urandom_range(0, 99) < sda_bias);
        return it;
    endfunction

    task automatic send_tick(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        ticks_sent++;
        last_quiet = !it.cmd_valid || (it.opcode > OP_STOP);
    endtask

    // one command transaction, then bus ticks until the engine is back to idle
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic dir,
                           input logic mack, input int bias);
        t_in_item it;
        sda_bias = bias;
        it = filler();
        it.cmd_valid = 1'b1;
        it.opcode = op;
        it.data_byte = data;
        it.read_dir = dir;
        it.master_ack = mack;
        send_tick(it);
        while (!(engine_idle && last_quiet)) send_tick(filler());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] unit, input logic [15:0] poll,
                             input logic [7:0] retry);
        settle();
        write_reg(CFG_UNIT_TICKS, unit);
        write_reg(CFG_ACK_POLL, poll);
        write_reg(CFG_ADDR_RETRY, {8'($urandom_range(0, 255)), retry});
    endtask

    task automatic random_transfer();
        logic dir;
        int   n;
        dir = 1'($urandom_range(0, 1));
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 7) == 0) begin
            run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_bias());
        end else begin
            run_cmd(OP_ADDR, 8'($urandom_range(0, 255)), dir, 1'b0, pick_bias());
            for (int i = 0; i < n; i++) begin
                if (dir) begin
                    run_cmd(OP_READ, 8'($urandom_range(0, 255)), dir, (i == n - 1), 50);
                end else begin
                    run_cmd(OP_SEND, 8'($urandom_range(0, 255)), dir, 1'b0, pick_bias());
                end
            end
            run_cmd(OP_STOP, 8'($urandom_range(0, 255)), dir, 1'b0, 50);
        end
    endtask

    initial begin
        int target;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        ticks_sent = 0;
        sda_bias = 50;
        noise_on = 1'b1;
        last_quiet = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0, 50);
        run_cmd(OP_ADDR, 8'hA4, 1'b0, 1'b0, 0);
        run_cmd(OP_SEND, 8'hFF, 1'b0, 1'b0, 0);
        run_cmd(OP_SEND, 8'h00, 1'b0, 1'b0, 85);
        run_cmd(OP_ADDR, 8'h5A, 1'b1, 1'b0, 0);
        run_cmd(OP_ADDR, 8'hFF, 1'b0, 1'b1, 0);
        run_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 100);
        run_cmd(OP_READ, 8'hFF, 1'b1, 1'b1, 0);
        run_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 50);
        run_cmd(OP_STOP, 8'hFF, 1'b1, 1'b1, 50);
        for (int k = OP_STOP + 1; k <= OP_LAST_CODE; k++) begin
            run_cmd(3'(k), 8'hFF, 1'b1, 1'b1, 50);
        end

        // no acknowledge on address and data
        configure(16'd1, 16'd1, 8'd1);
        run_cmd(OP_ADDR, 8'hFF, 1'b0, 1'b0, 100);
        run_cmd(OP_SEND, 8'h81, 1'b0, 1'b0, 100);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, 50);
        configure(16'd1, 16'd3, 8'd3);
        run_cmd(OP_ADDR, 8'h42, 1'b1, 1'b0, 100);
        run_cmd(OP_ADDR, 8'h43, 1'b0, 1'b0, 85);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, 50);

        // large limits
        noise_on = 1'b0;
        configure(16'd1, 16'hFFFF, 8'd1);
        run_cmd(OP_SEND, 8'hC3, 1'b0, 1'b0, 0);
        configure(16'd1, 16'd1, 8'hFF);
        run_cmd(OP_ADDR, 8'h3C, 1'b0, 1'b0, 50);
        configure(16'd20, 16'd1, 8'd1);
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0, 50);
        noise_on = 1'b1;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure(16'($urandom_range(1, 3)), 16'($urandom_range(1, 8)),
                      8'($urandom_range(1, 4)));
            if (p == 1) begin
                write_reg(CFG_NO_REG, 16'($urandom_range(0, 16'hFFFF)));
            end
            target = ticks_sent + RANDOM_TICKS / RANDOM_PHASES;
            while (ticks_sent < target) random_transfer();
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
